@@ rtl/histogram_cdf_normalizer_core_macros.svh @@
// Assertion shorthands; clk and rst are taken from the enclosing scope.
`ifndef HISTOGRAM_CDF_NORMALIZER_CORE_MACROS_SVH
`define HISTOGRAM_CDF_NORMALIZER_CORE_MACROS_SVH

// same-cycle implication
`define HCN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HCN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hcn_pkg.sv @@
package hcn_pkg;

  localparam int COUNT_W = 24;
  localparam int SUM_W   = 32;
  localparam int INDEX_W = 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } hcn_state_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

@@ rtl/histogram_cdf_normalizer_core.sv @@
// Channel | Dir | Signals                          | Word
// s       | in  | s_tvalid s_tready s_tdata s_tuser | load (count) or emit request
// m       | out | m_tvalid m_tready m_tdata m_tlast | one cumulative fraction per emit
//
// Loads are accepted back to back. An emit runs the restoring divider, which retires
// one quotient bit per cycle; a zero total skips the divider, and an emit on an empty
// store goes straight to the output stage.
// Not ready while an emit is in progress; a finished word waits in the output
// register and the next word is accepted meanwhile. Reset is synchronous and
// clears counters and totals; the count memory is not cleared.
module histogram_cdf_normalizer_core #(
  parameter int MAX_BINS      = 256,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [hcn_pkg::COUNT_W-1:0]           s_tdata,  // [23:0] count
  input  logic [0:0]                            s_tuser,  // [0] opcode
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // [7:0] bin_index, then fraction (FRACTION_BITS+1), empty_total,
  // overflow_dropped, zero fill
  output logic [((FRACTION_BITS+18)/8)*8-1:0]   m_tdata,
  output logic                                  m_tlast   // is_last
);
  import hcn_pkg::*;

  localparam int IDX_W  = $clog2(MAX_BINS);
  localparam int PTR_W  = $clog2(MAX_BINS + 1);
  localparam int FRAC_W = FRACTION_BITS + 1;
  localparam int QUO_W  = FRACTION_BITS + 2;
  localparam int NUM_W  = SUM_W + FRACTION_BITS + 1;
  localparam int CNT_W  = $clog2(NUM_W);
  localparam int OUT_W  = ((FRACTION_BITS + 18) / 8) * 8;
  localparam logic [QUO_W-1:0] ONE_Q = QUO_W'(1) << FRACTION_BITS;

  hcn_state_t state, state_next;

  logic [COUNT_W-1:0] mem [MAX_BINS];
  logic [COUNT_W-1:0] rd_data;

  logic [PTR_W-1:0] loaded;
  logic [PTR_W-1:0] ptr;
  logic [SUM_W-1:0] total;
  logic [SUM_W-1:0] rsum;
  logic             ovf_flag;
  logic             empty_case;

  logic [NUM_W-1:0] num;
  logic [SUM_W-1:0] rem;
  logic [QUO_W-1:0] quo;
  logic [CNT_W-1:0] bit_cnt;

  logic [INDEX_W-1:0] out_index;
  logic [FRAC_W-1:0]  out_frac;
  logic               out_last;
  logic               out_empty;
  logic               out_ovf;

  logic in_acc, load_go, emit_go, out_free, room;
  logic [SUM_W:0] trial;
  logic [SUM_W:0] diff;
  logic           ge;
  logic           last_hit;
  logic           zero_res;
  logic [FRAC_W-1:0] frac_res;
  logic [PTR_W+INDEX_W-1:0] idx_ext;

  assign in_acc   = s_tvalid && s_tready;
  assign load_go  = in_acc && (s_tuser[0] == OP_LOAD);
  assign emit_go  = in_acc && (s_tuser[0] == OP_EMIT);
  assign out_free = !m_tvalid || m_tready;
  assign room     = loaded < PTR_W'(MAX_BINS);

  // one restoring-division step
  assign trial = {rem, num[NUM_W-1]};
  assign ge    = trial >= {1'b0, total};
  assign diff  = trial - {1'b0, total};

  assign last_hit = empty_case || ((PTR_W+1)'(ptr) + 1'b1 == (PTR_W+1)'(loaded));
  assign zero_res = empty_case || (total == '0);
  assign frac_res = zero_res ? '0 :
                    (quo > ONE_Q) ? ONE_Q[FRAC_W-1:0] : quo[FRAC_W-1:0];
  assign idx_ext  = {{INDEX_W{1'b0}}, ptr};

  assign m_tdata = OUT_W'({out_ovf, out_empty, out_frac, out_index});
  assign m_tlast = out_last;

  always_comb begin
    state_next = state;
    s_tready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tuser[0] == OP_EMIT) begin
          state_next = (ptr >= loaded) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: state_next = ST_SUM;
      ST_SUM:  state_next = ST_PREP;
      ST_PREP: state_next = (total == '0) ? ST_DONE : ST_DIV;
      ST_DIV: begin
        if (bit_cnt == '0) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_go && room) mem[loaded[IDX_W-1:0]] <= s_tdata;
    rd_data <= mem[ptr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      loaded   <= '0;
      ptr      <= '0;
      total    <= '0;
      rsum     <= '0;
      ovf_flag <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // ST_DONE sets valid itself when the register frees up
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;

      if (load_go) begin
        if (room) begin
          loaded <= loaded + 1'b1;
          total  <= sat_add(total, SUM_W'(s_tdata));
        end else begin
          ovf_flag <= 1'b1;
        end
      end
      if (emit_go) empty_case <= (ptr >= loaded);

      case (state)
        ST_SUM: rsum <= sat_add(rsum, SUM_W'(rd_data));
        ST_PREP: begin
          // rounding: add half the divisor before dividing
          num     <= NUM_W'({rsum, {FRACTION_BITS{1'b0}}}) + NUM_W'(total >> 1);
          rem     <= '0;
          quo     <= '0;
          bit_cnt <= CNT_W'(NUM_W - 1);
        end
        ST_DIV: begin
          rem     <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
          quo     <= {quo[QUO_W-2:0], ge};
          num     <= num << 1;
          bit_cnt <= bit_cnt - 1'b1;
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid  <= 1'b1;
            out_index <= empty_case ? '0 : idx_ext[INDEX_W-1:0];
            out_frac  <= frac_res;
            out_last  <= last_hit;
            out_empty <= zero_res;
            out_ovf   <= ovf_flag;
            if (last_hit) begin
              loaded   <= '0;
              ptr      <= '0;
              total    <= '0;
              rsum     <= '0;
              ovf_flag <= 1'b0;
            end else begin
              ptr <= ptr + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/hcn_checker.sv @@
`include "histogram_cdf_normalizer_core_macros.svh"

module hcn_checker #(
  parameter int FRACTION_BITS = 16
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic [0:0]                          s_tuser,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [((FRACTION_BITS+18)/8)*8-1:0] m_tdata
);
  localparam int FRAC_LO = 8;
  localparam int EMPTY_B = FRAC_LO + FRACTION_BITS + 1;

  logic [FRACTION_BITS:0] frac;
  assign frac = m_tdata[FRAC_LO +: FRACTION_BITS+1];

  `HCN_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")
  // an emit occupies the block, so ready drops once it is taken
  `HCN_ASSERT_NEXT(a_emit_busy, s_tvalid && s_tready && s_tuser[0], !s_tready, "ready right after an emit")
  `HCN_ASSERT_NOW(a_frac_max, m_tvalid, frac <= ((FRACTION_BITS+1)'(1) << FRACTION_BITS), "fraction above one")
  `HCN_ASSERT_NOW(a_empty_zero, m_tvalid && m_tdata[EMPTY_B], frac == '0, "empty total with nonzero fraction")

endmodule

bind histogram_cdf_normalizer_core hcn_checker #(.FRACTION_BITS(FRACTION_BITS)) u_hcn_checker (.*);
